// ===== src/glu_activation_unit_defines.svh =====
// assertion macros used by the activation unit checker
`ifndef GLU_ACTIVATION_UNIT_DEFINES_SVH
`define GLU_ACTIVATION_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GLU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GLU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/glu_pkg.sv =====
package glu_pkg;

  // word format of the value, gate and result
  localparam int DATA_WIDTH      = 16;
  localparam int FRAC_BITS       = 12;
  localparam int TABLE_ADDR_BITS = 8;

  localparam int SEG_BITS    = DATA_WIDTH - TABLE_ADDR_BITS;
  localparam int TABLE_DEPTH = 1 << TABLE_ADDR_BITS;

  // sigmoid in unsigned Q0.16, one extra bit so that 1.0 fits
  localparam int SIG_FRAC = 16;
  localparam int SIG_BITS = SIG_FRAC + 1;

  // internal precision of the table generator
  localparam int          FX       = 40;
  localparam logic [63:0] FX_ONE   = 64'd1 << FX;
  localparam logic [63:0] SAT_MAG  = 64'd12;
  localparam int          EXP_TERMS = 40;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [SIG_BITS-1:0]          sig_t;
  typedef logic [TABLE_ADDR_BITS-1:0]   tab_idx_t;
  typedef logic [SEG_BITS-1:0]          seg_t;
  typedef sig_t                         sig_table_t [TABLE_DEPTH];

  // payload after the table lookup
  typedef struct packed {
    data_t value;
    sig_t  lo;
    sig_t  hi;
    seg_t  frac;
  } glu_lookup_t;

  // payload after the interpolation
  typedef struct packed {
    data_t value;
    sig_t  sig;
  } glu_gated_t;

  // (x * y) >> FX, exact 128-bit product
  function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] prod;
    begin
      prod = {64'd0, x} * {64'd0, y};
      return prod[FX+63:FX];
    end
  endfunction

  // restoring long division, table build only
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    begin
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
        rem = {rem[63:0], num[i]};
        if (rem >= {1'b0, den}) begin
          rem    = rem - {1'b0, den};
          quo[i] = 1'b1;
        end
      end
      return quo;
    end
  endfunction

  // e^r for r in [0, 1], both in Q(FX)
  function automatic logic [63:0] exp_unit(input logic [63:0] r);
    logic [63:0] sum;
    logic [63:0] term;
    logic        done;
    begin
      sum  = FX_ONE;
      term = FX_ONE;
      done = 1'b0;
      for (int k = 1; k <= EXP_TERMS; k++) begin
        if (!done) begin
          term = long_div(fx_mul(term, r), 64'(k));
          if (term == 64'd0) done = 1'b1;
          else sum = sum + term;
        end
      end
      return sum;
    end
  endfunction

  // round(65536 * sigmoid(v / 2^FRAC_BITS))
  function automatic sig_t sig_entry(input longint v);
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] e1;
    logic [63:0] ex;
    logic [63:0] d;
    logic [63:0] low;
    begin
      mag = (v < 0) ? 64'(-v) : 64'(v);
      q   = mag >> FRAC_BITS;
      if (q >= SAT_MAG) begin
        low = 64'd0;
      end else begin
        r  = (mag & ((64'd1 << FRAC_BITS) - 64'd1)) << (FX - FRAC_BITS);
        e1 = exp_unit(FX_ONE);
        ex = exp_unit(r);
        for (int i = 0; i < 12; i++) begin
          if (64'(i) < q) ex = fx_mul(ex, e1);
        end
        d   = FX_ONE + ex;
        low = long_div((64'd1 << (SIG_FRAC + 1 + FX)) + d, d << 1);
      end
      if (v > 0) low = (64'd1 << SIG_FRAC) - low;
      return low[SIG_BITS-1:0];
    end
  endfunction

  // table of sigmoid at segment starts, shifted by offset entries
  function automatic sig_table_t build_table(input int offset);
    sig_table_t t;
    longint     v;
    begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        v    = (longint'(i + offset) <<< SEG_BITS) - (longint'(1) <<< (DATA_WIDTH - 1));
        t[i] = sig_entry(v);
      end
      return t;
    end
  endfunction

  // lower and upper ends of each segment
  localparam sig_table_t SIG_LO = build_table(0);
  localparam sig_table_t SIG_HI = build_table(1);

endpackage

// ===== src/glu_channels.sv =====
// value/gate pair channel
interface glu_pair_if;
  import glu_pkg::*;
  logic  valid;
  logic  ready;
  data_t value_in;
  data_t gate_in;
  modport source (output valid, output value_in, output gate_in, input ready);
  modport sink (input valid, input value_in, input gate_in, output ready);
  modport monitor (input valid, input value_in, input gate_in, input ready);
endinterface

// result channel
interface glu_result_if;
  import glu_pkg::*;
  logic  valid;
  logic  ready;
  data_t glu_out;
  modport source (output valid, output glu_out, input ready);
  modport sink (input valid, input glu_out, output ready);
  modport monitor (input valid, input glu_out, input ready);
endinterface

// ===== src/glu_activation_unit.sv =====
// channel | role   | payload
// pair    | sink   | value_in, gate_in (signed Q4.12)
// result  | source | glu_out (signed Q4.12)
//
// one word per cycle while result is not stalled
// stages: sigmoid table lookup, segment interpolation, product and rounding
// the product stage register is the output register
// rst clears the stage valid bits only; nothing else needs a reset
// a stall on result backs up stage by stage; pair.ready stays high while any
// stage is empty, so up to three words wait inside without loss

module glu_activation_unit
  import glu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  glu_pair_if.sink     pair,
  glu_result_if.source result
);

  logic        lk_valid;
  logic        lk_ready;
  glu_lookup_t lk_data;
  logic        ip_valid;
  logic        ip_ready;
  glu_gated_t  ip_data;

  // table lookup
  glu_sig_lookup u_lookup (
    .clk        (clk),
    .rst        (rst),
    .prev_valid (pair.valid),
    .prev_ready (pair.ready),
    .value      (pair.value_in),
    .gate       (pair.gate_in),
    .valid      (lk_valid),
    .ready      (lk_ready),
    .data       (lk_data)
  );

  // linear interpolation
  glu_interp u_interp (
    .clk        (clk),
    .rst        (rst),
    .prev_valid (lk_valid),
    .prev_ready (lk_ready),
    .prev_data  (lk_data),
    .valid      (ip_valid),
    .ready      (ip_ready),
    .data       (ip_data)
  );

  // gating product
  glu_mul_round u_mul (
    .clk        (clk),
    .rst        (rst),
    .prev_valid (ip_valid),
    .prev_ready (ip_ready),
    .prev_data  (ip_data),
    .valid      (result.valid),
    .ready      (result.ready),
    .data       (result.glu_out)
  );

endmodule

// ===== src/glu_sig_lookup.sv =====
module glu_sig_lookup
  import glu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        prev_valid,
  output logic        prev_ready,
  input  data_t       value,
  input  data_t       gate,
  output logic        valid,
  input  logic        ready,
  output glu_lookup_t data
);

  logic        gate_msb_n;
  tab_idx_t    idx;
  seg_t        frac;
  glu_lookup_t data_next;

  // gate plus half scale: flip the sign bit, then split
  assign gate_msb_n = ~gate[DATA_WIDTH-1];
  assign idx        = {gate_msb_n, gate[DATA_WIDTH-2:SEG_BITS]};
  assign frac       = gate[SEG_BITS-1:0];

  // segment ends from the two tables
  always_comb begin
    data_next.value = value;
    data_next.lo    = SIG_LO[idx];
    data_next.hi    = SIG_HI[idx];
    data_next.frac  = frac;
  end

  // stage moves when empty or when its word leaves
  assign prev_ready = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (prev_ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_valid && prev_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== src/glu_interp.sv =====
module glu_interp
  import glu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        prev_valid,
  output logic        prev_ready,
  input  glu_lookup_t prev_data,
  output logic        valid,
  input  logic        ready,
  output glu_gated_t  data
);

  sig_t                        diff;
  logic [SIG_BITS+SEG_BITS-1:0] step_prod;
  sig_t                        step;
  glu_gated_t                  data_next;

  // rising step only, a falling one counts as flat
  assign diff      = (prev_data.hi >= prev_data.lo) ? (prev_data.hi - prev_data.lo) : '0;
  assign step_prod = {{SEG_BITS{1'b0}}, diff} * {{SIG_BITS{1'b0}}, prev_data.frac};
  assign step      = step_prod[SIG_BITS+SEG_BITS-1:SEG_BITS];

  always_comb begin
    data_next.value = prev_data.value;
    data_next.sig   = prev_data.lo + step;
  end

  assign prev_ready = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (prev_ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_valid && prev_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== src/glu_mul_round.sv =====
module glu_mul_round
  import glu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       prev_valid,
  output logic       prev_ready,
  input  glu_gated_t prev_data,
  output logic       valid,
  input  logic       ready,
  output data_t      data
);

  localparam int PROD_BITS = DATA_WIDTH + SIG_BITS + 1;
  localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (SIG_FRAC - 1);

  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] rounded;

  // signed value times unsigned sigmoid, round half up, floor shift
  assign prod    = PROD_BITS'(prev_data.value) * PROD_BITS'($signed({1'b0, prev_data.sig}));
  assign rounded = prod + ROUND_HALF;

  assign prev_ready = !valid || ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (prev_ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_valid && prev_ready) begin
      data <= rounded[SIG_FRAC+DATA_WIDTH-1:SIG_FRAC];
    end
  end

endmodule

// ===== src/glu_activation_unit_checker.sv =====
`include "glu_activation_unit_defines.svh"

module glu_activation_unit_checker
  import glu_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  pair_valid,
  input logic  pair_ready,
  input logic  result_valid,
  input logic  result_ready,
  input data_t glu_out
);

  logic       in_word;
  logic       out_word;
  logic       out_stall;
  logic [2:0] inflight;

  assign in_word   = pair_valid && pair_ready;
  assign out_word  = result_valid && result_ready;
  assign out_stall = result_valid && !result_ready;

  // words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + {2'b0, in_word} - {2'b0, out_word};
    end
  end

  // never more words inside than there are stages
  `GLU_ASSERT_NOW(a_depth, clk, rst, 1'b1, inflight <= 3'd3, "more words in flight than stages")

  // no result without a word inside
  `GLU_ASSERT_NOW(a_no_ghost, clk, rst, result_valid, inflight != 3'd0, "result with empty pipeline")

  // input backpressure only when the output is stalled
  `GLU_ASSERT_NOW(a_bp_cause, clk, rst, !pair_ready, out_stall, "pair stalled while output drains")

  // stalled result holds its word
  `GLU_ASSERT_NEXT(a_hold, clk, rst, out_stall, result_valid && $stable(glu_out), "stalled result changed")

endmodule

bind glu_activation_unit glu_activation_unit_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .pair_valid   (pair.valid),
  .pair_ready   (pair.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .glu_out      (result.glu_out)
);

// ===== tb/glu_checker.sv =====
`timescale 1ns / 1ps

module glu_checker
  import glu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  glu_pair_if.monitor       pair,
  glu_result_if.monitor     result,
  output int                errors,
  output int                pending
);

  localparam int          FIX = 40;
  localparam logic [63:0] FIX_ONE = 64'd1 << FIX;

  typedef struct {
    data_t value;
    data_t gate;
    data_t glu;
  } glu_expect_t;

  // sigmoid at every segment start, plus the closing entry
  logic [SIG_BITS-1:0] sigmoid_rom [TABLE_DEPTH+1];
  logic [63:0]         e_one;
  glu_expect_t         expected_glu [$];

  // (x * y) >> FIX, full product
  function automatic logic [63:0] fix_product(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] wide;
    wide = {64'd0, x} * {64'd0, y};
    return wide[FIX+63:FIX];
  endfunction

  // e^r by its taylor series, r in [0, 1]
  function automatic logic [63:0] exp_series(input logic [63:0] r);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = FIX_ONE;
    term = FIX_ONE;
    for (int k = 1; k <= 40; k++) begin
      term = fix_product(term, r) / 64'(k);
      if (term == 64'd0) break;
      sum = sum + term;
    end
    return sum;
  endfunction

  // round(2^16 * sigmoid(v / 2^FRAC_BITS)), via 1 / (1 + e^|x|)
  function automatic logic [SIG_BITS-1:0] sigmoid_q16(input longint v);
    logic [63:0] mag;
    logic [63:0] whole;
    logic [63:0] ex;
    logic [63:0] den;
    logic [63:0] low;
    mag   = (v < 0) ? 64'(-v) : 64'(v);
    whole = mag >> FRAC_BITS;
    if (whole >= 64'd12) begin
      // far tails are pinned to exactly 0 or 1
      low = 64'd0;
    end else begin
      ex = exp_series((mag & ((64'd1 << FRAC_BITS) - 64'd1)) << (FIX - FRAC_BITS));
      for (longint i = 0; i < longint'(whole); i++) ex = fix_product(ex, e_one);
      den = FIX_ONE + ex;
      low = ((64'd1 << (17 + FIX)) + den) / (den << 1);
    end
    if (v > 0) low = 64'd65536 - low;
    return low[SIG_BITS-1:0];
  endfunction

  // value times interpolated sigmoid of gate, rounded half up
  function automatic data_t gated_value(input data_t a, input data_t b);
    logic [DATA_WIDTH-1:0] biased;
    int                    idx;
    longint                frac;
    longint                lo_s;
    longint                hi_s;
    longint                diff;
    longint                sig;
    longint                prod;
    biased = DATA_WIDTH'(b) ^ DATA_WIDTH'(1 << (DATA_WIDTH - 1));
    idx    = int'(biased >> SEG_BITS);
    frac   = longint'(biased & DATA_WIDTH'((1 << SEG_BITS) - 1));
    lo_s   = longint'(sigmoid_rom[idx]);
    hi_s   = longint'(sigmoid_rom[idx+1]);
    diff   = (hi_s >= lo_s) ? hi_s - lo_s : 0;
    sig    = lo_s + ((diff * frac) >>> SEG_BITS);
    prod   = longint'(a) * sig + 32768;
    return data_t'(prod >>> 16);
  endfunction

  initial begin
    e_one   = exp_series(FIX_ONE);
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      sigmoid_rom[i] = sigmoid_q16((longint'(i) <<< SEG_BITS) - (longint'(1) <<< (DATA_WIDTH - 1)));
    end
  end

  // record accepted pairs, compare accepted results in order
  always @(posedge clk) begin
    glu_expect_t head;
    if (!rst) begin
      if (pair.valid && pair.ready) begin
        expected_glu.push_back('{pair.value_in, pair.gate_in,
                                 gated_value(pair.value_in, pair.gate_in)});
      end
      if (result.valid && result.ready) begin
        if (expected_glu.size() == 0) begin
          $display("%0t: unexpected glu_out word %0d, expected none", $time, result.glu_out);
          errors++;
        end else begin
          head = expected_glu.pop_front();
          if (result.glu_out !== head.glu) begin
            $display("%0t: glu_out mismatch for value %0d gate %0d: expected %0d, actual %0d",
                     $time, head.value, head.gate, head.glu, result.glu_out);
            errors++;
          end
        end
      end
    end
    pending = expected_glu.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import glu_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_START  = 300;
  localparam int HOLD_LEN    = 60;
  localparam int CALM_START  = 600;
  localparam int CALM_END    = 850;
  localparam int RANDOM_WORDS = 800;

  logic clk;
  logic rst;
  int   chk_errors;
  int   chk_pending;
  int   cycle_count;
  int   sink_cycle;
  bit   send_idles;

  glu_pair_if   pair_ch ();
  glu_result_if result_ch ();

  glu_activation_unit dut (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair_ch),
    .result (result_ch)
  );

  glu_checker chk (
    .clk     (clk),
    .rst     (rst),
    .pair    (pair_ch),
    .result  (result_ch),
    .errors  (chk_errors),
    .pending (chk_pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, one calm stretch
  always @(negedge clk) begin
    sink_cycle++;
    if (sink_cycle >= HOLD_START && sink_cycle < HOLD_START + HOLD_LEN)
      result_ch.ready = 1'b0;
    else if (sink_cycle >= CALM_START && sink_cycle < CALM_END)
      result_ch.ready = 1'b1;
    else
      result_ch.ready = ($urandom_range(99) >= 8);
  end

  // offer one word at a falling edge and hold it until accepted
  task automatic send_pair(input data_t value, input data_t gate);
    while (send_idles && $urandom_range(99) < 8) begin
      pair_ch.valid = 1'b0;
      @(negedge clk);
    end
    pair_ch.valid    = 1'b1;
    pair_ch.value_in = value;
    pair_ch.gate_in  = gate;
    do @(posedge clk); while (!pair_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    data_t value;
    data_t gate;
    int    mode;

    rst              = 1'b1;
    send_idles       = 1'b1;
    pair_ch.valid    = 1'b0;
    pair_ch.value_in = '0;
    pair_ch.gate_in  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // value extremes against gate extremes and the midpoint
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh7FFF, 16'sh0000);
    send_pair(16'sh8000, 16'sh0000);
    send_pair(16'sh0000, 16'sh7FFF);
    send_pair(16'sh0000, 16'sh8000);
    // half-way products round up: +1 gives 1, -1 gives 0
    send_pair(16'sh0001, 16'sh0000);
    send_pair(-16'sd1, 16'sh0000);
    send_pair(16'sh0003, 16'sh0000);
    send_pair(-16'sd3, 16'sh0000);
    // top segment, interpolated towards the closing entry
    send_pair(16'sh1000, 16'sh7F00);
    send_pair(16'sh1000, 16'sh7F80);
    send_pair(-16'sh1000, 16'sh7FFE);
    // segment edges and near-saturated gate
    send_pair(16'sh1000, 16'sh00FF);
    send_pair(16'sh1000, 16'sh0100);
    send_pair(16'sh1000, -16'sh0001);
    send_pair(16'sh1000, 16'sh8001);
    send_pair(16'sh5A5A, 16'sh6000);
    send_pair(-16'sh5A5A, -16'sh6000);
    send_pair(16'shFFFF, 16'sh1234);

    // random pairs, weighted towards the steep middle, segment edges and value extremes
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_idles = !(n >= 400 && n < 550);
      mode  = $urandom_range(9);
      value = data_t'($urandom);
      gate  = data_t'($urandom);
      case (mode)
        6, 7: gate = data_t'($urandom_range(16383) - 8192);
        8: gate = {gate[15:8], ($urandom_range(1) != 0) ? 8'hFF : 8'h00};
        9: value = ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
        default: ;
      endcase
      send_pair(value, gate);
    end
    pair_ch.valid = 1'b0;

    // drain, then wait for stray words
    while (chk_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (chk_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/glu_pkg.sv
src/glu_channels.sv
src/glu_sig_lookup.sv
src/glu_interp.sv
src/glu_mul_round.sv
src/glu_activation_unit.sv
src/glu_activation_unit_checker.sv
tb/glu_checker.sv
tb/tb_top.sv
